// ----- rtl/rmf_pkg.sv -----
package rmf_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 8;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned MEDIAN_W       = SAMPLE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_HOLD
  } ctrl_state_e;

  // rank unit status seen by the top level
  typedef struct packed {
    logic                       done;
    logic signed [MEDIAN_W-1:0] median_doubled;
  } rank_status_t;

endpackage

// ----- rtl/running_median_filter_core.sv -----
// running median filter: each input transaction carries one signed 16-bit
// sample that overwrites the oldest of the last WINDOW_LEN samples, and one
// output transaction returns twice the median of that window (17 bits, one
// fractional bit, exact). the window starts as all zeros, so during warm-up
// the reset zeros take part in the ranking. the window sits in a small
// two-read-port memory; a rank unit sweeps every entry against every other
// entry, one pair per cycle, counting how many lie below and not above it,
// and picks the entries that land on the middle ranks. the block takes one
// sample at a time: its input stays stalled from acceptance until the result
// is loaded into the output register. the output register lets the next
// sample be taken while a result is still waiting downstream.
module running_median_filter_core #(
  parameter int unsigned WINDOW_LEN = rmf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rmf_pkg::MEDIAN_W-1:0] median_doubled_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

  rmf_pkg::ctrl_state_e  state_q, state_d;
  rmf_pkg::rank_status_t rank_status;

  logic                 in_accept;
  logic                 out_free;
  logic                 load_out;
  logic [IDX_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [rmf_pkg::MEDIAN_W-1:0] median_q;
  logic [IDX_W-1:0]     rd_addr_a, rd_addr_b;
  logic signed [rmf_pkg::SAMPLE_W-1:0] rd_data_a, rd_data_b;

  assign in_accept = in_valid_i && !in_stall_o;
  // output slot is free when empty or being emptied this cycle
  assign out_free  = !out_valid_q || !out_stall_i;

  // control: idle -> rank the window -> hand result to the output register
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      rmf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = rmf_pkg::ST_RANK;
        end
      end
      rmf_pkg::ST_RANK: begin
        if (rank_status.done) begin
          state_d = rmf_pkg::ST_HOLD;
        end
      end
      rmf_pkg::ST_HOLD: begin
        // result stays in the rank unit until the output register takes it
        if (out_free) begin
          load_out = 1'b1;
          state_d  = rmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmf_pkg::ST_IDLE;
      end
    endcase
  end

  // oldest entry pointer, wraps at the window length
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (in_accept) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmf_pkg::ST_IDLE;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      median_q <= rank_status.median_doubled;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;

  rmf_window_mem #(
    .WINDOW_LEN (WINDOW_LEN),
    .IDX_W      (IDX_W)
  ) u_window_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_accept),
    .wr_addr_i   (wr_ptr_q),
    .wr_data_i   (sample_i),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // sweep starts on the accept edge, so its first read sees the new sample
  rmf_rank_unit #(
    .WINDOW_LEN (WINDOW_LEN),
    .IDX_W      (IDX_W)
  ) u_rank_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .status_o    (rank_status)
  );

endmodule

// ----- rtl/rmf_window_mem.sv -----
module rmf_window_mem #(
  parameter int unsigned WINDOW_LEN = rmf_pkg::WINDOW_LEN_DEF,
  parameter int unsigned IDX_W      = $clog2(WINDOW_LEN)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [IDX_W-1:0]                    wr_addr_i,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]                    rd_addr_a_i,
  input  logic [IDX_W-1:0]                    rd_addr_b_i,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] rd_data_a_o,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] rd_data_b_o
);

  logic signed [rmf_pkg::SAMPLE_W-1:0] mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]               written_q;
  logic [WINDOW_LEN-1:0]               written_d;

  // entries not yet written read as zero
  always_comb begin
    written_d = written_q;
    if (wr_en_i) begin
      written_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else begin
      written_q <= written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= written_q[rd_addr_a_i] ? mem[rd_addr_a_i] : '0;
    rd_data_b_o <= written_q[rd_addr_b_i] ? mem[rd_addr_b_i] : '0;
  end

endmodule

// ----- rtl/rmf_rank_unit.sv -----
module rmf_rank_unit #(
  parameter int unsigned WINDOW_LEN = rmf_pkg::WINDOW_LEN_DEF,
  parameter int unsigned IDX_W      = $clog2(WINDOW_LEN)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic [IDX_W-1:0]                    rd_addr_a_o,
  output logic [IDX_W-1:0]                    rd_addr_b_o,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] rd_data_a_i,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] rd_data_b_i,
  output rmf_pkg::rank_status_t               status_o
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned LO_POS = (WINDOW_LEN - 1) / 2;
  localparam int unsigned HI_POS = WINDOW_LEN / 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0] LO_RANK  = CNT_W'(LO_POS);
  localparam logic [CNT_W-1:0] HI_RANK  = CNT_W'(HI_POS);

  logic                  run_q, run_d;
  logic [IDX_W-1:0]      cand_q, cand_d;
  logic [IDX_W-1:0]      cmp_q, cmp_d;
  logic                  dv_q, last_cmp_q, last_all_q, done_q;
  logic [CNT_W-1:0]      lt_q, le_q;
  logic [CNT_W-1:0]      lt_sum, le_sum;
  logic signed [rmf_pkg::SAMPLE_W-1:0] lo_q, hi_q;

  // address sweep: every candidate against every entry
  always_comb begin
    run_d  = run_q;
    cand_d = cand_q;
    cmp_d  = cmp_q;
    if (start_i) begin
      run_d  = 1'b1;
      cand_d = '0;
      cmp_d  = '0;
    end else if (run_q) begin
      if (cmp_q == LAST_IDX) begin
        cmp_d = '0;
        if (cand_q == LAST_IDX) begin
          run_d = 1'b0;
        end else begin
          cand_d = cand_q + 1'b1;
        end
      end else begin
        cmp_d = cmp_q + 1'b1;
      end
    end
  end

  assign rd_addr_a_o = cand_q;
  assign rd_addr_b_o = cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      cand_q     <= '0;
      cmp_q      <= '0;
      dv_q       <= 1'b0;
      last_cmp_q <= 1'b0;
      last_all_q <= 1'b0;
      done_q     <= 1'b0;
      lt_q       <= '0;
      le_q       <= '0;
    end else begin
      run_q      <= run_d;
      cand_q     <= cand_d;
      cmp_q      <= cmp_d;
      dv_q       <= run_q;
      last_cmp_q <= run_q && (cmp_q == LAST_IDX);
      last_all_q <= run_q && (cmp_q == LAST_IDX) && (cand_q == LAST_IDX);
      done_q     <= dv_q && last_all_q;
      if (dv_q) begin
        if (last_cmp_q) begin
          lt_q <= '0;
          le_q <= '0;
        end else begin
          lt_q <= lt_sum;
          le_q <= le_sum;
        end
      end
    end
  end

  // count entries below and not above the candidate
  assign lt_sum = lt_q + CNT_W'(rd_data_b_i <  rd_data_a_i);
  assign le_sum = le_q + CNT_W'(rd_data_b_i <= rd_data_a_i);

  // candidate covers sorted positions lt .. le-1
  always_ff @(posedge clk_i) begin
    if (dv_q && last_cmp_q) begin
      if ((lt_sum <= LO_RANK) && (LO_RANK < le_sum)) begin
        lo_q <= rd_data_a_i;
      end
      if ((lt_sum <= HI_RANK) && (HI_RANK < le_sum)) begin
        hi_q <= rd_data_a_i;
      end
    end
  end

  assign status_o.done           = done_q;
  assign status_o.median_doubled = {lo_q[rmf_pkg::SAMPLE_W-1], lo_q}
                                 + {hi_q[rmf_pkg::SAMPLE_W-1], hi_q};

endmodule

// ----- rtl/rmf_checker.sv -----
module rmf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [rmf_pkg::SAMPLE_W-1:0] sample_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [rmf_pkg::MEDIAN_W-1:0] median_doubled_o
);

  // stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("stalled output transaction changed");

  // stalled sample stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled input transaction changed");

  // input side is stalled while a sample is being ranked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("new sample taken while ranking");

  // a result only appears at the end of a ranking pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output transaction without a ranked sample");

  // input side stays free while idle and no sample arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i |=> !in_stall_o)
    else $error("stall raised with no sample taken");

endmodule

bind running_median_filter_core rmf_checker u_rmf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .sample_i         (sample_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .median_doubled_o (median_doubled_o)
);

// ----- tb/running_median_filter_core_tb.sv -----
`timescale 1ns / 100ps

module running_median_filter_core_tb;

  localparam int unsigned WLEN      = rmf_pkg::WINDOW_LEN_DEF;
  localparam int unsigned SAMPLE_W  = rmf_pkg::SAMPLE_W;
  localparam int unsigned MEDIAN_W  = rmf_pkg::MEDIAN_W;
  // acceptance to loaded result, plus some slack for the output register
  localparam int unsigned SETTLE_CY = WLEN * WLEN + 16;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [MEDIAN_W-1:0] median_doubled_o;

  // shadow of the window in arrival order and of the oldest-entry index
  logic signed [SAMPLE_W-1:0] win_shadow [WLEN];
  int unsigned                oldest_idx;

  // expected doubled medians, oldest first
  logic signed [MEDIAN_W-1:0] median_q [$];

  int  mismatch_cnt = 0;
  bit  idle_on      = 1'b1;
  int  stall_left   = 0;
  int  walk_val     = 0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  running_median_filter_core #(
    .WINDOW_LEN(WLEN)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .median_doubled_o(median_doubled_o)
  );

  always #5 clk_i = ~clk_i;

  // ranks a copy of the shadow window and returns the sum of the middle ranks
  function automatic logic signed [MEDIAN_W-1:0] window_median_x2();
    logic signed [SAMPLE_W-1:0] ranked [WLEN];
    logic signed [SAMPLE_W-1:0] key;
    logic signed [MEDIAN_W-1:0] lo;
    logic signed [MEDIAN_W-1:0] hi;
    int j;
    ranked = win_shadow;
    for (int i = 1; i < WLEN; i++) begin
      key = ranked[i];
      j   = i - 1;
      while (j >= 0 && ranked[j] > key) begin
        ranked[j + 1] = ranked[j];
        j--;
      end
      ranked[j + 1] = key;
    end
    if (WLEN % 2 == 0) begin
      lo = MEDIAN_W'(ranked[WLEN / 2 - 1]);
      hi = MEDIAN_W'(ranked[WLEN / 2]);
    end else begin
      lo = MEDIAN_W'(ranked[WLEN / 2]);
      hi = MEDIAN_W'(ranked[WLEN / 2]);
    end
    return lo + hi;
  endfunction

  task automatic report_mismatch(input string what, input logic [MEDIAN_W-1:0] got,
                                 input logic [MEDIAN_W-1:0] want);
    $display("%0t ns: mismatch, %s: got %0d want %0d", $time, what,
             $signed(got), $signed(want));
    mismatch_cnt++;
  endtask

  // drives one sample and waits until the input transaction completes;
  // valid stays high across back-to-back items
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transaction taken at this edge: update the shadow and predict
    win_shadow[oldest_idx] = s;
    oldest_idx = (oldest_idx == WLEN - 1) ? 0 : oldest_idx + 1;
    median_q.push_back(window_median_x2());
    last_sample = s;
  endtask

  // output side: random stall bursts and the result check
  always @(posedge clk_i) begin
    logic signed [MEDIAN_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (median_q.size() == 0) begin
        report_mismatch("result with nothing pending", median_doubled_o, '0);
      end else begin
        want = median_q.pop_front();
        if (median_doubled_o !== want)
          report_mismatch("median_doubled", median_doubled_o, want);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 7) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // reset zeros rank with real samples until the window fills
  task automatic test_warmup();
    push_sample(16'sh1234);
    push_sample(-16'sd1000);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    push_sample(16'sd7);
    push_sample(-16'sd7);
  endtask

  // full-scale windows, all ties, then a mixed window around the rails
  task automatic test_extremes();
    repeat (WLEN) push_sample(16'sh7FFF);
    repeat (WLEN) push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
  endtask

  // sensor-like mix: raw noise, slow drift, small ties, rails, near-rail values, repeats
  task automatic test_random_mix(input int n);
    logic signed [SAMPLE_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: s = SAMPLE_W'($urandom());
        3, 4, 5: begin
          walk_val += int'($urandom_range(0, 1024)) - 512;
          if (walk_val > 32767)  walk_val = 32767;
          if (walk_val < -32768) walk_val = -32768;
          s = SAMPLE_W'(walk_val);
        end
        6: s = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
        7: begin
          case ($urandom_range(0, 3))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2: s = 16'sh0000;
            default: s = 16'shFFFF;
          endcase
        end
        8: s = last_sample;
        default: begin
          if ($urandom_range(0, 1)) s = SAMPLE_W'(32767 - int'($urandom_range(0, 15)));
          else                      s = SAMPLE_W'(-32768 + int'($urandom_range(0, 15)));
        end
      endcase
      push_sample(s);
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_steady_stream(input int n);
    idle_on = 1'b0;
    test_random_mix(n);
  endtask

  initial begin
    foreach (win_shadow[i]) win_shadow[i] = '0;
    oldest_idx = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warmup();
    test_extremes();
    test_random_mix(1775);
    test_steady_stream(50);

    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CY) @(posedge clk_i);

    if (mismatch_cnt == 0 && median_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
